### sv/abtt_pkg.sv
`timescale 1ns / 1ps
package abtt_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] batch_len;
        logic [31:0] timestamp_ms;
        logic [15:0] forced_timeout_ms;
    } abtt_in_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [19:0] mean_batch;
        logic [16:0] avg_utilization;
        logic [31:0] rate_q16;
    } abtt_out_t;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 35;
    localparam int LOG_XW = 13;
    localparam int LOG_RW = 20;
    localparam int LOG_STEPS = 16;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [LOG_XW-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic              done;
        logic [LOG_RW-1:0] result;
    } log_rsp_t;

endpackage

### sv/adaptive_batch_timeout_tuner.sv
`timescale 1ns / 1ps
// Channel  Ports                      Moves
// s_       s_valid s_ready s_data     one event per transaction
// m_       m_valid m_ready m_data     one result per event
// cfg_     cfg_valid cfg_ready        register index and data
//          cfg_addr cfg_data
// Batch-done events use up to two log2 passes and up to four passes of the
// shared radix-2 divider. Arrival events use one divider pass when their
// timestamp advances; force and unused events use neither. One event is in
// work at a time; the result register frees s_ready before m_ready. Reset is
// synchronous, active low; the window memory needs no clearing pass.
module adaptive_batch_timeout_tuner
    import abtt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  abtt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output abtt_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_addr,
    input  logic [31:0] cfg_data
);

    localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SSW = 12 + CW;
    localparam int USW = 17 + CW;

    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_MIN     = 3'd1;
    localparam logic [2:0] REG_MAX     = 3'd2;
    localparam logic [2:0] REG_GROW    = 3'd3;
    localparam logic [2:0] REG_SHRINK  = 3'd4;
    localparam logic [2:0] REG_TUTIL   = 3'd5;
    localparam logic [2:0] REG_WEIGHT  = 3'd6;
    localparam logic [2:0] REG_IRATE   = 3'd7;

    localparam logic [1:0] MODE_BATCH  = 2'd0;
    localparam logic [1:0] MODE_ARRIVE = 2'd1;
    localparam logic [1:0] MODE_FORCE  = 2'd2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOGT  = 4'd1;
    localparam logic [3:0] ST_LOGB  = 4'd2;
    localparam logic [3:0] ST_UDIV  = 4'd3;
    localparam logic [3:0] ST_UPD   = 4'd4;
    localparam logic [3:0] ST_DAB   = 4'd5;
    localparam logic [3:0] ST_DAU   = 4'd6;
    localparam logic [3:0] ST_RT    = 4'd7;
    localparam logic [3:0] ST_IDEAL = 4'd8;
    localparam logic [3:0] ST_CLAMP = 4'd9;
    localparam logic [3:0] ST_ADIV  = 4'd10;
    localparam logic [3:0] ST_EMA1  = 4'd11;
    localparam logic [3:0] ST_EMA2  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    localparam logic [16:0] UTIL_FLOOR = 17'd2032;
    localparam logic [16:0] UTIL_ONE   = 17'd65536;

    function automatic logic [15:0] clamp_ms(logic [29:0] v, logic [15:0] lo,
                                             logic [15:0] hi);
        if (v < 30'(lo)) begin
            return lo;
        end else if (v > 30'(hi)) begin
            return hi;
        end
        return v[15:0];
    endfunction

    logic [11:0] target_reg;
    logic [15:0] min_reg, max_reg, grow_reg;
    logic [12:0] shrink_reg;
    logic [16:0] tutil_reg, weight_reg;
    logic [31:0] irate_reg;

    logic [3:0]     state_reg;
    abtt_in_t       item_reg;
    logic [AW-1:0]  ptr_reg;
    logic [CW-1:0]  fill_reg;
    logic [SSW-1:0] size_sum_reg;
    logic [USW-1:0] util_sum_reg;
    logic [15:0]    timeout_reg;
    logic [31:0]    rate_reg, pend_reg, last_reg, inst_reg;
    logic [19:0]    avg_b_reg;
    logic [16:0]    avg_u_reg;
    logic [16:0]    util_reg;
    logic [19:0]    lt_reg;
    logic [41:0]    nv_reg;
    logic [48:0]    p1_reg, p2_reg;
    abtt_out_t      out_reg;
    logic           m_valid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;
    log_req_t log_req;
    log_rsp_t log_rsp;

    logic           s_fire;
    logic           out_load;
    logic           ram_we;
    logic [28:0]    ram_rdata;
    logic           full;
    logic [CW-1:0]  fill_next;
    logic [SSW-1:0] size_sum_next;
    logic [USW-1:0] util_sum_next;
    logic [31:0]    pend_inc;
    logic [16:0]    w_sat;
    logic [22:0]    a_x5, t_x1536;
    logic [20:0]    u_x10, tu_x7;
    logic           small_batch, large_batch, low_util;
    logic [31:0]    grown;
    logic [28:0]    shrunk;
    logic [49:0]    ema_sum;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign full          = (fill_reg == CW'(HISTORY_DEPTH));
    assign fill_next     = full ? fill_reg : fill_reg + CW'(1);
    assign size_sum_next = size_sum_reg - (full ? SSW'(ram_rdata[28:17]) : '0)
                           + SSW'(item_reg.batch_len);
    assign util_sum_next = util_sum_reg - (full ? USW'(ram_rdata[16:0]) : '0)
                           + USW'(util_reg);
    assign ram_we        = (state_reg == ST_UPD);

    assign pend_inc = (pend_reg == '1) ? pend_reg : pend_reg + 32'd1;
    assign w_sat    = (weight_reg > UTIL_ONE) ? UTIL_ONE : weight_reg;

    assign a_x5        = {1'b0, avg_b_reg, 2'b0} + 23'(avg_b_reg);
    assign t_x1536     = 23'({target_reg, 10'b0}) + 23'({target_reg, 9'b0});
    assign u_x10       = {1'b0, avg_u_reg, 3'b0} + 21'({avg_u_reg, 1'b0});
    assign tu_x7       = {1'b0, tutil_reg, 3'b0} - 21'(tutil_reg);
    assign small_batch = avg_b_reg < {1'b0, target_reg, 7'b0};
    assign large_batch = a_x5 > t_x1536;
    assign low_util    = u_x10 < tu_x7;
    assign grown       = 32'(timeout_reg) * 32'(grow_reg);
    assign shrunk      = 29'(timeout_reg) * 29'(shrink_reg);
    assign ema_sum     = 50'(p1_reg) + 50'(p2_reg);

    always_comb begin
        div_req = '0;
        log_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.mode == MODE_BATCH && s_data.batch_len > 12'd1) begin
                    log_req.start = 1'b1;
                    log_req.x     = LOG_XW'(target_reg) + LOG_XW'(1);
                end
                if (s_fire && s_data.mode == MODE_ARRIVE && s_data.timestamp_ms > last_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'({pend_inc, 16'b0});
                    div_req.divisor  = DIV_DW'(s_data.timestamp_ms - last_reg);
                end
            end
            ST_LOGT: begin
                if (log_rsp.done && log_rsp.result != '0) begin
                    log_req.start = 1'b1;
                    log_req.x     = LOG_XW'(item_reg.batch_len) + LOG_XW'(1);
                end
            end
            ST_LOGB: begin
                if (log_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'({log_rsp.result, 16'b0});
                    div_req.divisor  = DIV_DW'(lt_reg);
                end
            end
            ST_UPD: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'({size_sum_next, 8'b0});
                div_req.divisor  = DIV_DW'(fill_next);
            end
            ST_DAB: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'(util_sum_reg);
                    div_req.divisor  = DIV_DW'(fill_reg);
                end
            end
            ST_RT: begin
                if (small_batch && rate_reg != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'({target_reg, 30'b0});
                    div_req.divisor  = DIV_DW'({rate_reg, 2'b0}) + DIV_DW'(rate_reg);
                end
            end
            default: begin
            end
        endcase
    end

    abtt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    abtt_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (log_req),
        .rsp     (log_rsp)
    );

    abtt_ram #(
        .WIDTH (29),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata ({item_reg.batch_len, util_reg}),
        .re    (s_fire),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 12'd64;
            min_reg    <= 16'd1;
            max_reg    <= 16'd100;
            grow_reg   <= 16'd4915;
            shrink_reg <= 13'd3686;
            tutil_reg  <= 17'd52429;
            weight_reg <= 17'd6554;
            irate_reg  <= 32'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_TARGET: target_reg <= cfg_data[11:0];
                REG_MIN:    min_reg    <= cfg_data[15:0];
                REG_MAX:    max_reg    <= cfg_data[15:0];
                REG_GROW:   grow_reg   <= cfg_data[15:0];
                REG_SHRINK: shrink_reg <= cfg_data[12:0];
                REG_TUTIL:  tutil_reg  <= cfg_data[16:0];
                REG_WEIGHT: weight_reg <= cfg_data[16:0];
                REG_IRATE:  irate_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            size_sum_reg <= '0;
            util_sum_reg <= '0;
            timeout_reg  <= '0;
            rate_reg     <= 32'd65536;
            pend_reg     <= '0;
            last_reg     <= '0;
            avg_b_reg    <= '0;
            avg_u_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        item_reg <= s_data;
                        unique case (s_data.mode)
                            MODE_BATCH: begin
                                if (s_data.batch_len > 12'd1) begin
                                    state_reg <= ST_LOGT;
                                end else begin
                                    util_reg  <= UTIL_FLOOR;
                                    state_reg <= ST_UPD;
                                end
                            end
                            MODE_ARRIVE: begin
                                pend_reg  <= pend_inc;
                                state_reg <= (s_data.timestamp_ms > last_reg) ? ST_ADIV
                                                                               : ST_OUT;
                            end
                            MODE_FORCE: begin
                                timeout_reg <= clamp_ms(30'(s_data.forced_timeout_ms),
                                                        min_reg, max_reg);
                                state_reg   <= ST_OUT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_LOGT: begin
                    if (log_rsp.done) begin
                        lt_reg <= log_rsp.result;
                        if (log_rsp.result == '0) begin
                            util_reg  <= UTIL_ONE;
                            state_reg <= ST_UPD;
                        end else begin
                            state_reg <= ST_LOGB;
                        end
                    end
                end
                ST_LOGB: begin
                    if (log_rsp.done) begin
                        state_reg <= ST_UDIV;
                    end
                end
                ST_UDIV: begin
                    if (div_rsp.done) begin
                        util_reg  <= (div_rsp.quotient > DIV_NW'(UTIL_ONE)) ? UTIL_ONE
                                     : div_rsp.quotient[16:0];
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    fill_reg     <= fill_next;
                    size_sum_reg <= size_sum_next;
                    util_sum_reg <= util_sum_next;
                    ptr_reg      <= (ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                    : ptr_reg + AW'(1);
                    state_reg    <= ST_DAB;
                end
                ST_DAB: begin
                    if (div_rsp.done) begin
                        avg_b_reg <= div_rsp.quotient[19:0];
                        state_reg <= ST_DAU;
                    end
                end
                ST_DAU: begin
                    if (div_rsp.done) begin
                        avg_u_reg <= div_rsp.quotient[16:0];
                        state_reg <= ST_RT;
                    end
                end
                ST_RT: begin
                    state_reg <= (small_batch && rate_reg != '0) ? ST_IDEAL : ST_CLAMP;
                    if (small_batch) begin
                        nv_reg <= 42'(grown);
                    end else if (large_batch) begin
                        nv_reg <= 42'(shrunk);
                    end else if (low_util) begin
                        nv_reg <= 42'(grown);
                    end else begin
                        nv_reg <= 42'({timeout_reg, 12'b0});
                    end
                end
                ST_IDEAL: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient[41:0] > nv_reg) begin
                            nv_reg <= div_rsp.quotient[41:0];
                        end
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    timeout_reg <= clamp_ms(nv_reg[41:12], min_reg, max_reg);
                    state_reg   <= ST_OUT;
                end
                ST_ADIV: begin
                    if (div_rsp.done) begin
                        inst_reg  <= (div_rsp.quotient[47:32] != '0) ? '1
                                     : div_rsp.quotient[31:0];
                        p1_reg    <= 49'(rate_reg) * 49'(UTIL_ONE - w_sat);
                        state_reg <= ST_EMA1;
                    end
                end
                ST_EMA1: begin
                    p2_reg    <= 49'(inst_reg) * 49'(w_sat);
                    state_reg <= ST_EMA2;
                end
                ST_EMA2: begin
                    rate_reg  <= ema_sum[47:16];
                    pend_reg  <= '0;
                    last_reg  <= item_reg.timestamp_ms;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_reg.timeout_ms      <= timeout_reg;
                        out_reg.mean_batch      <= avg_b_reg;
                        out_reg.avg_utilization <= avg_u_reg;
                        out_reg.rate_q16        <= rate_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/abtt_ram.sv
`timescale 1ns / 1ps
module abtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/abtt_div.sv
`timescale 1ns / 1ps
module abtt_div
    import abtt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] div_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, q_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_NW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg   <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(shifted - {1'b0, div_reg}) : shifted[DIV_DW-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

### sv/abtt_log.sv
`timescale 1ns / 1ps
module abtt_log
    import abtt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  log_req_t req,
    output log_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  n_reg;
    logic [15:0] frac_reg;
    logic [30:0] m_reg;
    logic [3:0]  n_start;
    logic [30:0] m_start;
    logic [61:0] square;
    logic [31:0] sq_top;

    always_comb begin
        n_start = '0;
        for (int i = 0; i < LOG_XW; i++) begin
            if (req.x[i]) begin
                n_start = 4'(i);
            end
        end
    end

    assign m_start = 31'({req.x, 30'b0} >> n_start);
    assign square  = 62'(m_reg) * 62'(m_reg);
    assign sq_top  = square[61:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(LOG_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            n_reg    <= n_start;
            m_reg    <= m_start;
            frac_reg <= '0;
        end else if (busy_reg) begin
            frac_reg <= {frac_reg[14:0], sq_top[31]};
            m_reg    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {n_reg, frac_reg};

endmodule
